// File: hdl/iss_pkg.sv
package iss_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int POS_W        = 7;
	localparam int CNT_W        = 7;
	localparam int VAL_W        = 32;
	localparam int GROUP        = 32;

	localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

	typedef enum logic [1:0] {
		OP_HEAD = 2'd0,
		OP_TAIL = 2'd1,
		OP_AT   = 2'd2,
		OP_READ = 2'd3
	} op_e_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_e_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CELL,
		S_TREE
	} state_e_t;

	// strobes broadcast to every cell at the accept edge
	typedef struct packed {
		logic load;
		logic insert;
		logic read;
	} cell_ctl_t;

endpackage

// File: hdl/iss_if.sv
interface iss_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [iss_pkg::POS_W-1:0]              position;
	logic [1:0]                             opcode;
	logic signed [iss_pkg::VAL_W-1:0]       item_value;

	modport source (output valid, output opcode, output position, output item_value,
		input ready);
	modport sink (input valid, input opcode, input position, input item_value,
		output ready);
endinterface

interface iss_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [iss_pkg::VAL_W-1:0]       read_value;
	logic [1:0]                             status;
	logic [iss_pkg::CNT_W-1:0]              count_now;

	modport source (output valid, output read_value, output status, output count_now,
		input ready);
	modport sink (input valid, input read_value, input status, input count_now,
		output ready);
endinterface

// File: hdl/indexed_sequence_store.sv
// Indexed sequence store.
// Holds an ordered list of up to CAPACITY signed 32-bit values and a count.
// req channel: opcode (head insert, tail insert, insert at position, read at
// position), position and item_value. rsp channel: read_value, status
// (ok, index out of range, full) and count_now, one rsp item per req item.
// Each entry lives in a cell of a chain; an insert makes every cell above the
// insertion point take its lower neighbour's value in the accept cycle.
// A read is served by gating the addressed cell and collecting the cells
// through a two-level registered OR tree of 32-way groups.
// The result of an accepted item passes the cell and tree stages and is then
// loaded into the output register, which the receiver may hold. One item is in
// flight at a time; req.ready rises again as the result is loaded.
// While rsp is stalled with a result waiting, the next item is taken but its
// result waits in the tree stage until the output register is free.
// Reset clears the count and the control state; entry contents are not
// cleared and only entries below the count are ever read.
module indexed_sequence_store #(
	parameter int CAPACITY = iss_pkg::CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	iss_in_if.sink    req,
	iss_out_if.source rsp
);

	localparam int IW   = $clog2(CAPACITY + 1);
	localparam int CW   = (IW > iss_pkg::POS_W) ? IW : iss_pkg::POS_W;
	localparam int CNTW = iss_pkg::CNT_W;

	iss_pkg::state_e_t state_q, state_d;
	iss_pkg::op_e_t    op;
	iss_pkg::status_e_t status_d, status_s1, status_q;
	iss_pkg::cell_ctl_t ctl;

	logic [IW-1:0]   count_q, count_d;
	logic [CW-1:0]   cnt_x, pos_x, where;
	logic            accept, range_bad, full, ins_ok, out_load;
	logic            bad_s1;
	logic [CNTW-1:0] cnt_s1, cnt_out_q;
	logic            out_valid_q;
	logic signed [iss_pkg::VAL_W-1:0] value_q, tree_result;
	logic signed [iss_pkg::VAL_W-1:0] ent [CAPACITY];
	logic signed [iss_pkg::VAL_W-1:0] rd  [CAPACITY];

	assign accept = req.valid && req.ready;
	assign op     = iss_pkg::op_e_t'(req.opcode);
	assign cnt_x  = CW'(count_q);
	assign pos_x  = CW'(req.position);

	always_comb begin
		case (op)
			iss_pkg::OP_HEAD: where = '0;
			iss_pkg::OP_TAIL: where = cnt_x;
			default:          where = pos_x;
		endcase
	end

	assign range_bad = (op == iss_pkg::OP_READ) ? (pos_x >= cnt_x) :
		((op == iss_pkg::OP_AT) && (pos_x > cnt_x));
	assign full      = (count_q == IW'(CAPACITY));
	assign ins_ok    = (op != iss_pkg::OP_READ) && !range_bad && !full;
	assign count_d   = count_q + IW'(ins_ok);

	always_comb begin
		if (range_bad) begin
			status_d = iss_pkg::ST_RANGE;
		end else if (op != iss_pkg::OP_READ && full) begin
			status_d = iss_pkg::ST_FULL;
		end else begin
			status_d = iss_pkg::ST_OK;
		end
	end

	assign ctl.load   = accept;
	assign ctl.insert = accept && ins_ok;
	assign ctl.read   = (op == iss_pkg::OP_READ) && !range_bad;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		iss_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.where      (where),
			.pos        (pos_x),
			.ins_value  (req.item_value),
			.prev_value ((i == 0) ? req.item_value : ent[(i == 0) ? 0 : i - 1]),
			.entry      (ent[i]),
			.rd_s1      (rd[i])
		);
	end

	iss_or_tree #(
		.CAPACITY (CAPACITY)
	) u_tree (
		.clk    (clk),
		.grp_en (state_q == iss_pkg::S_CELL),
		.leaf   (rd),
		.result (tree_result)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			bad_s1    <= range_bad;
			cnt_s1    <= CNTW'(CW'(count_d));
		end
		if (out_load) begin
			value_q   <= bad_s1 ? iss_pkg::MISS_VALUE : tree_result;
			status_q  <= status_s1;
			cnt_out_q <= cnt_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iss_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q <= count_d;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			iss_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = iss_pkg::S_CELL;
				end
			end
			iss_pkg::S_CELL: begin
				state_d = iss_pkg::S_TREE;
			end
			iss_pkg::S_TREE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = iss_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = iss_pkg::S_IDLE;
			end
		endcase
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = value_q;
	assign rsp.status     = status_q;
	assign rsp.count_now  = cnt_out_q;

	a_accept_to_cell: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == iss_pkg::S_CELL)
		else $error("accepted item did not enter the cell stage");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= IW'(CAPACITY))
		else $error("count above capacity");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && ins_ok) |=> $stable(count_q))
		else $error("count changed without an insert");

	a_range_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == iss_pkg::ST_RANGE) |->
		rsp.read_value == iss_pkg::MISS_VALUE)
		else $error("out of range result without the miss value");

endmodule

// File: hdl/iss_cell.sv
module iss_cell #(
	parameter int CAPACITY = iss_pkg::CAPACITY_DEF,
	parameter int INDEX    = 0,
	localparam int IW      = $clog2(CAPACITY + 1),
	localparam int CW      = (IW > iss_pkg::POS_W) ? IW : iss_pkg::POS_W
) (
	input  logic                             clk,
	input  iss_pkg::cell_ctl_t               ctl,
	input  logic [CW-1:0]                    where,
	input  logic [CW-1:0]                    pos,
	input  logic signed [iss_pkg::VAL_W-1:0] ins_value,
	input  logic signed [iss_pkg::VAL_W-1:0] prev_value,
	output logic signed [iss_pkg::VAL_W-1:0] entry,
	output logic signed [iss_pkg::VAL_W-1:0] rd_s1
);

	localparam logic [CW-1:0] IDX = CW'(INDEX);

	logic signed [iss_pkg::VAL_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (where == IDX) begin
				entry_q <= ins_value;
			end else if (where < IDX) begin
				entry_q <= prev_value;
			end
		end
		if (ctl.load) begin
			rd_s1 <= (ctl.read && pos == IDX) ? entry_q : '0;
		end
	end

	assign entry = entry_q;

endmodule

// File: hdl/iss_or_tree.sv
module iss_or_tree #(
	parameter int CAPACITY = iss_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             grp_en,
	input  logic signed [iss_pkg::VAL_W-1:0] leaf [CAPACITY],
	output logic signed [iss_pkg::VAL_W-1:0] result
);

	localparam int NG = (CAPACITY + iss_pkg::GROUP - 1) / iss_pkg::GROUP;

	logic signed [iss_pkg::VAL_W-1:0] grp_or [NG];
	logic signed [iss_pkg::VAL_W-1:0] grp_s2 [NG];

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < iss_pkg::GROUP; k++) begin
				if (g * iss_pkg::GROUP + k < CAPACITY) begin
					grp_or[g] = grp_or[g] | leaf[g * iss_pkg::GROUP + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grp_en) begin
			for (int g = 0; g < NG; g++) begin
				grp_s2[g] <= grp_or[g];
			end
		end
	end

	always_comb begin
		result = '0;
		for (int g = 0; g < NG; g++) begin
			result = result | grp_s2[g];
		end
	end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int DEPTH        = iss_pkg::CAPACITY_DEF;
	localparam int VAL_W        = iss_pkg::VAL_W;
	localparam int CNT_W        = iss_pkg::CNT_W;
	localparam int POS_W        = iss_pkg::POS_W;
	localparam logic [VAL_W-1:0] MISS = iss_pkg::MISS_VALUE;
	localparam int RANDOM_ITEMS = 830;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 400;
	localparam int PAUSE_AT     = 500;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN        = 20;

	typedef struct packed {
		logic [VAL_W-1:0]   rv;
		iss_pkg::status_e_t st;
		logic [CNT_W-1:0]   cnt;
	} outcome_t;

	typedef struct {
		iss_pkg::op_e_t   op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		bit               fixed;
		outcome_t         res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	iss_in_if  req_if ();
	iss_out_if rsp_if ();

	indexed_sequence_store #(.CAPACITY(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	logic [VAL_W-1:0] cells [DEPTH];
	int               held = 0;
	outcome_t         awaited [$];
	int               fails = 0;
	int               rsp_seen = 0;
	bit               tx_calm = 1'b0;
	bit               rx_calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirror of the list: applies one item, returns the result it should give
	function automatic outcome_t list_step(iss_pkg::op_e_t op, logic [POS_W-1:0] pos,
		logic [VAL_W-1:0] val);
		outcome_t o;
		int       where;
		o = '{rv: '0, st: iss_pkg::ST_OK, cnt: '0};
		if (op == iss_pkg::OP_READ) begin
			if (int'(pos) >= held) begin
				o.rv = MISS;
				o.st = iss_pkg::ST_RANGE;
			end else begin
				o.rv = cells[int'(pos)];
			end
		end else begin
			where = (op == iss_pkg::OP_HEAD) ? 0 : (op == iss_pkg::OP_TAIL) ? held : int'(pos);
			if (op == iss_pkg::OP_AT && int'(pos) > held) begin
				o.rv = MISS;
				o.st = iss_pkg::ST_RANGE;
			end else if (held >= DEPTH) begin
				o.st = iss_pkg::ST_FULL;
			end else begin
				for (int i = held; i > where; i--)
					cells[i] = cells[i-1];
				cells[where] = val;
				held++;
			end
		end
		o.cnt = CNT_W'(held);
		return o;
	endfunction

	// entered and left at a falling edge
	task automatic issue_item(iss_pkg::op_e_t op, logic [POS_W-1:0] pos,
		logic [VAL_W-1:0] val, bit fixed, outcome_t res);
		int       gap;
		outcome_t o;
		if ($urandom_range(0, 39) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid      = 1'b1;
		req_if.opcode     = op;
		req_if.position   = pos;
		req_if.item_value = val;
		do @(posedge clk); while (!req_if.ready);
		o = list_step(op, pos, val);
		awaited.push_back(fixed ? res : o);
		@(negedge clk);
	endtask

	initial begin
		outcome_t got;
		outcome_t want;
		int       gap;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rsp_seen == HOLD_AT) begin
				rsp_if.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if ($urandom_range(0, 39) == 0)
				rx_calm = !rx_calm;
			gap = rx_calm ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				rsp_if.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_if.ready = 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
			rsp_seen++;
			got = '{rv: rsp_if.read_value, st: iss_pkg::status_e_t'(rsp_if.status),
				cnt: rsp_if.count_now};
			if (awaited.size() == 0) begin
				fails++;
				$display("%0t unexpected item: read_value %h status %0d count_now %0d",
					$time, got.rv, got.st, got.cnt);
			end else begin
				want = awaited.pop_front();
				if (got.rv !== want.rv) begin
					fails++;
					$display("%0t read_value expected %h got %h", $time, want.rv, got.rv);
				end
				if (got.st !== want.st) begin
					fails++;
					$display("%0t status expected %0d got %0d", $time, want.st, got.st);
				end
				if (got.cnt !== want.cnt) begin
					fails++;
					$display("%0t count_now expected %0d got %0d", $time, want.cnt, got.cnt);
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		row_t             plan [$];
		iss_pkg::op_e_t   op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		int               r;

		req_if.valid      = 1'b0;
		req_if.opcode     = iss_pkg::OP_HEAD;
		req_if.position   = '0;
		req_if.item_value = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		plan = '{
			'{iss_pkg::OP_READ, 7'd0,   32'h0,        1'b1, '{MISS, iss_pkg::ST_RANGE, 7'd0}},
			'{iss_pkg::OP_READ, 7'd127, 32'h0,        1'b1, '{MISS, iss_pkg::ST_RANGE, 7'd0}},
			'{iss_pkg::OP_AT,   7'd1,   32'h5,        1'b1, '{MISS, iss_pkg::ST_RANGE, 7'd0}},
			'{iss_pkg::OP_AT,   7'd127, 32'h5,        1'b1, '{MISS, iss_pkg::ST_RANGE, 7'd0}},
			'{iss_pkg::OP_TAIL, 7'd127, 32'h7fffffff, 1'b1, '{32'h0, iss_pkg::ST_OK, 7'd1}},
			'{iss_pkg::OP_HEAD, 7'd0,   32'h80000000, 1'b1, '{32'h0, iss_pkg::ST_OK, 7'd2}},
			'{iss_pkg::OP_READ, 7'd0,   32'h0,        1'b1,
				'{32'h80000000, iss_pkg::ST_OK, 7'd2}},
			'{iss_pkg::OP_READ, 7'd1,   32'hffffffff, 1'b1,
				'{32'h7fffffff, iss_pkg::ST_OK, 7'd2}},
			'{iss_pkg::OP_READ, 7'd2,   32'h0,        1'b1, '{MISS, iss_pkg::ST_RANGE, 7'd2}},
			// insert at the count, at zero and in the middle
			'{iss_pkg::OP_AT,   7'd2,   32'hffffffff, 1'b0, '0},
			'{iss_pkg::OP_AT,   7'd0,   32'h0,        1'b0, '0},
			'{iss_pkg::OP_AT,   7'd1,   32'h55555555, 1'b0, '0},
			'{iss_pkg::OP_AT,   7'd2,   32'haaaaaaaa, 1'b0, '0},
			'{iss_pkg::OP_AT,   7'd7,   32'h1,        1'b1, '{MISS, iss_pkg::ST_RANGE, 7'd6}},
			'{iss_pkg::OP_AT,   7'd6,   32'h12345678, 1'b0, '0},
			'{iss_pkg::OP_HEAD, 7'd64,  32'hdeadbeef, 1'b0, '0},
			'{iss_pkg::OP_READ, 7'd0,   32'h0,        1'b0, '0},
			'{iss_pkg::OP_READ, 7'd1,   32'h0,        1'b0, '0},
			'{iss_pkg::OP_READ, 7'd2,   32'h0,        1'b0, '0},
			'{iss_pkg::OP_READ, 7'd3,   32'h0,        1'b0, '0},
			'{iss_pkg::OP_READ, 7'd4,   32'h0,        1'b0, '0},
			'{iss_pkg::OP_READ, 7'd5,   32'h0,        1'b0, '0},
			'{iss_pkg::OP_READ, 7'd6,   32'h0,        1'b0, '0},
			'{iss_pkg::OP_READ, 7'd7,   32'h0,        1'b0, '0},
			'{iss_pkg::OP_READ, 7'd8,   32'h0,        1'b1, '{MISS, iss_pkg::ST_RANGE, 7'd8}},
			'{iss_pkg::OP_READ, 7'd64,  32'h0,        1'b1, '{MISS, iss_pkg::ST_RANGE, 7'd8}}
		};
		foreach (plan[i])
			issue_item(plan[i].op, plan[i].pos, plan[i].val, plan[i].fixed, plan[i].res);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == PAUSE_AT) begin
				req_if.valid = 1'b0;
				while (awaited.size() != 0) @(negedge clk);
			end
			case ($urandom_range(0, 7))
				0: val = 32'h7fffffff;
				1: val = 32'h80000000;
				2: val = '1;
				3: val = '0;
				default: val = $urandom;
			endcase
			r = $urandom_range(0, 99);
			if (r < ((held < DEPTH) ? 30 : 20)) begin
				op = iss_pkg::op_e_t'($urandom_range(0, 2));
				if ($urandom_range(0, 4) == 0)
					pos = POS_W'($urandom_range(0, 127));
				else
					pos = POS_W'($urandom_range(0, held));
			end else begin
				op = iss_pkg::OP_READ;
				if (held > 0 && $urandom_range(0, 6) != 0)
					pos = POS_W'($urandom_range(0, held - 1));
				else
					pos = POS_W'($urandom_range(0, 127));
			end
			issue_item(op, pos, val, 1'b0, '0);
		end

		req_if.valid = 1'b0;
		while (awaited.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
